/* hw/rtl/uft_pkg.sv */
// Shared types, codes and constants for the URL field tokenizer.
package uft_pkg;

  // Field tags carried on the result channel.
  localparam logic [2:0] TAG_SCHEME    = 3'd0;
  localparam logic [2:0] TAG_DELIM     = 3'd1;
  localparam logic [2:0] TAG_HOST      = 3'd2;
  localparam logic [2:0] TAG_PORT      = 3'd3;
  localparam logic [2:0] TAG_PATH      = 3'd4;
  localparam logic [2:0] TAG_QUERY     = 3'd5;
  localparam logic [2:0] TAG_AFTER_ERR = 3'd6;

  // Delimiter characters.
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;

  // Known schemes in priority order: http, https, rtsp, ldap.
  localparam int unsigned NUM_SCHEMES = 4;
  localparam logic [15:0] PORT_RESET = 16'd80;
  localparam logic [9:0]  PORT_HTTP  = 10'd80;
  localparam logic [9:0]  PORT_HTTPS = 10'd443;
  localparam logic [9:0]  PORT_RTSP  = 10'd554;
  localparam logic [9:0]  PORT_LDAP  = 10'd389;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_SCHEME = 8'b0000_0001,
    PH_SLASH1 = 8'b0000_0010,
    PH_SLASH2 = 8'b0000_0100,
    PH_HOST   = 8'b0000_1000,
    PH_PORT   = 8'b0001_0000,
    PH_PATH   = 8'b0010_0000,
    PH_QUERY  = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } uft_phase_t;

  // Per-URL parse state.
  typedef struct packed {
    uft_phase_t  phase;
    logic [15:0] port;
    logic        digits_open;
    logic [2:0]  scheme_len;
    logic [3:0]  scheme_match;
  } uft_state_t;

  // One tagged byte with its end-of-URL report.
  typedef struct packed {
    logic [2:0]  tag;
    logic [7:0]  byte_val;
    logic        done;
    logic [15:0] port_value;
    logic [9:0]  scheme_port;
    logic        is_default;
    logic        format_error;
  } uft_result_t;

  localparam uft_state_t STATE_RESET = '{
    phase:        PH_SCHEME,
    port:         PORT_RESET,
    digits_open:  1'b0,
    scheme_len:   3'd0,
    scheme_match: 4'hF
  };

  // Default port of scheme k.
  function automatic logic [9:0] scheme_default(input logic [1:0] k);
    logic [9:0] p;
    case (k)
      2'd0:    p = PORT_HTTP;
      2'd1:    p = PORT_HTTPS;
      2'd2:    p = PORT_RTSP;
      default: p = PORT_LDAP;
    endcase
    return p;
  endfunction

  // True when byte c matches character idx of scheme k.
  function automatic logic scheme_char_ok(input logic [1:0] k, input logic [2:0] idx,
                                          input logic [7:0] c);
    logic [7:0] ch;
    logic       in_range;
    in_range = 1'b1;
    ch       = 8'h00;
    case (k)
      2'd0, 2'd1: begin
        case (idx)
          3'd0:    ch = 8'h68; // h
          3'd1:    ch = 8'h74; // t
          3'd2:    ch = 8'h74; // t
          3'd3:    ch = 8'h70; // p
          3'd4:    begin
            ch       = 8'h73; // s
            in_range = (k == 2'd1);
          end
          default: in_range = 1'b0;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    ch = 8'h72; // r
          3'd1:    ch = 8'h74; // t
          3'd2:    ch = 8'h73; // s
          3'd3:    ch = 8'h70; // p
          default: in_range = 1'b0;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    ch = 8'h6C; // l
          3'd1:    ch = 8'h64; // d
          3'd2:    ch = 8'h61; // a
          3'd3:    ch = 8'h70; // p
          default: in_range = 1'b0;
        endcase
      end
    endcase
    return in_range && (ch == c);
  endfunction

endpackage

/* hw/rtl/uft_parse.sv */
// Per-byte parse step: tag, next state and end-of-URL report.
module uft_parse (
  input  uft_pkg::uft_state_t  state_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output uft_pkg::uft_state_t  state_o,
  output uft_pkg::uft_result_t result_o
);

  uft_pkg::uft_state_t st;
  logic [2:0]          tag;
  logic                is_digit;
  logic [15:0]         port_x10;
  logic [9:0]          sport;
  logic                found;
  logic                is_def;

  assign is_digit = (char_i >= uft_pkg::CH_DIGIT_LO) && (char_i <= uft_pkg::CH_DIGIT_HI);
  // Times ten as two shifted copies, wrapping modulo 65536.
  assign port_x10 = {state_i.port[12:0], 3'b000} + {state_i.port[14:0], 1'b0};

  // Phase transitions and field tag.
  always_comb begin
    st  = state_i;
    tag = uft_pkg::TAG_AFTER_ERR;
    case (state_i.phase)
      uft_pkg::PH_SCHEME: begin
        if (char_i == uft_pkg::CH_COLON) begin
          tag      = uft_pkg::TAG_DELIM;
          st.phase = uft_pkg::PH_SLASH1;
        end else begin
          tag = uft_pkg::TAG_SCHEME;
          for (int k = 0; k < uft_pkg::NUM_SCHEMES; k++) begin
            if (!uft_pkg::scheme_char_ok(2'(k), state_i.scheme_len, char_i)) begin
              st.scheme_match[k] = 1'b0;
            end
          end
          if (state_i.scheme_len != 3'd7) begin
            st.scheme_len = state_i.scheme_len + 3'd1;
          end
        end
      end
      uft_pkg::PH_SLASH1, uft_pkg::PH_SLASH2: begin
        if (char_i == uft_pkg::CH_SLASH) begin
          tag      = uft_pkg::TAG_DELIM;
          st.phase = (state_i.phase == uft_pkg::PH_SLASH1) ? uft_pkg::PH_SLASH2
                                                           : uft_pkg::PH_HOST;
        end else begin
          tag      = uft_pkg::TAG_AFTER_ERR;
          st.phase = uft_pkg::PH_ERROR;
        end
      end
      uft_pkg::PH_HOST, uft_pkg::PH_PORT: begin
        if (char_i == uft_pkg::CH_COLON) begin
          // Every host-part colon restarts the port.
          tag            = uft_pkg::TAG_DELIM;
          st.port        = 16'd0;
          st.digits_open = 1'b1;
          st.phase       = uft_pkg::PH_PORT;
        end else if (char_i == uft_pkg::CH_SLASH) begin
          tag      = uft_pkg::TAG_DELIM;
          st.phase = uft_pkg::PH_PATH;
        end else if (state_i.phase == uft_pkg::PH_HOST) begin
          tag = uft_pkg::TAG_HOST;
        end else begin
          tag = uft_pkg::TAG_PORT;
          if (is_digit && state_i.digits_open) begin
            st.port = port_x10 + {12'd0, char_i[3:0]};
          end else begin
            st.digits_open = 1'b0;
          end
        end
      end
      uft_pkg::PH_PATH: begin
        if (char_i == uft_pkg::CH_QUESTION) begin
          tag      = uft_pkg::TAG_DELIM;
          st.phase = uft_pkg::PH_QUERY;
        end else begin
          tag = uft_pkg::TAG_PATH;
        end
      end
      uft_pkg::PH_QUERY: begin
        tag = uft_pkg::TAG_QUERY;
      end
      default: begin
        tag = uft_pkg::TAG_AFTER_ERR;
      end
    endcase
  end

  // Scheme default port (first match wins) and default-port flag.
  always_comb begin
    sport  = uft_pkg::PORT_HTTP;
    found  = 1'b0;
    is_def = 1'b0;
    for (int k = 0; k < uft_pkg::NUM_SCHEMES; k++) begin
      if (st.scheme_match[k]) begin
        if (!found) begin
          sport = uft_pkg::scheme_default(2'(k));
        end
        found = 1'b1;
        if (st.port == {6'd0, uft_pkg::scheme_default(2'(k))}) begin
          is_def = 1'b1;
        end
      end
    end
  end

  // Result assembly; the report fields are zero except on the last byte.
  always_comb begin
    result_o.tag          = tag;
    result_o.byte_val     = char_i;
    result_o.done         = last_i;
    result_o.port_value   = last_i ? st.port : 16'd0;
    result_o.scheme_port  = last_i ? sport : 10'd0;
    result_o.is_default   = last_i && is_def;
    result_o.format_error = last_i && ((st.phase == uft_pkg::PH_ERROR) ||
                                       (st.phase == uft_pkg::PH_SCHEME) ||
                                       (st.phase == uft_pkg::PH_SLASH1) ||
                                       (st.phase == uft_pkg::PH_SLASH2));
  end

  // A finished URL returns the parser to its reset state.
  assign state_o = last_i ? uft_pkg::STATE_RESET : st;

endmodule

/* hw/rtl/url_field_tokenizer.sv */
// Top level of the URL field tokenizer: input register, parse step, result register.
//
//  Channel | Ports                          | Request content
//  --------+--------------------------------+-------------------------------------------
//  input   | in_tvalid/tready/tdata/tlast   | one URL byte; tlast marks the final byte
//  result  | out_tvalid/tready/tdata/tuser/ | tagged byte; tlast and the report on the
//          | tlast                          | result for the final byte
//
// One byte per cycle sustained while out_tready holds; a taken request goes from the input
// register through the combinational parse step into the result register, and the
// parse state advances only when a byte moves into the result register.
// rst_n (synchronous, active low) empties both registers and resets the parse state.
// A stalled result register holds the input register; the input side still takes a
// request whenever its register is empty or moving on.
module url_field_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] byte_out, [23:8] port_value, [33:24] scheme_port,
                                  // [34] port_is_default, [35] format_error, [39:36] zero
  output logic [2:0]  out_tuser,  // [2:0] field_tag
  output logic        out_tlast   // url_done
);

  logic                 in_valid_r;
  logic [7:0]           in_char_r;
  logic                 in_last_r;
  logic                 out_valid_r;
  uft_pkg::uft_result_t out_res_r;
  uft_pkg::uft_state_t  state_r;
  uft_pkg::uft_state_t  state_nxt;
  uft_pkg::uft_result_t res_nxt;
  logic                 adv;

  // A byte advances when the result register is free or being drained.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  uft_parse u_parse (
    .state_i  (state_r),
    .char_i   (in_char_r),
    .last_i   (in_last_r),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uft_pkg::STATE_RESET;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.tag;
  assign out_tlast  = out_res_r.done;
  assign out_tdata  = {4'd0, out_res_r.format_error, out_res_r.is_default,
                       out_res_r.scheme_port, out_res_r.port_value, out_res_r.byte_val};

  // A finished URL leaves the parser in its reset state.
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (state_r == uft_pkg::STATE_RESET))
    else $error("parse state not reset after last byte");

  // Report fields stay zero on results that do not end a URL.
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.done) |-> (out_tdata[39:8] == 32'd0))
    else $error("report fields set on a byte that is not last");

  // A byte tagged after an error at the end of a URL always reports a format error.
  a_err_tag_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done && (out_res_r.tag == uft_pkg::TAG_AFTER_ERR))
      |-> out_res_r.format_error)
    else $error("error tag without format error");

  // Scheme match bits only clear once scheme bytes have been counted.
  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.scheme_len == 3'd0) |-> (state_r.scheme_match == 4'hF))
    else $error("scheme match cleared with empty scheme");

  // The phase register always holds exactly one phase.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("phase register not one-hot");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the URL field tokenizer stream block.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_BYTES = 450;
  localparam int unsigned QUIET_TAIL   = 60;   // last requests run with no idling
  localparam int unsigned LONG_HOLD    = 40;   // receiver hold-off, in cycles
  localparam int unsigned HOLD_AT      = 150;  // results seen before the hold-off
  localparam int unsigned DRAIN_AT     = 230;  // request index where the sender drains
  localparam int unsigned MAX_PRINTS   = 40;

  // One row of stimulus; typed rows carry an expectation written by hand.
  typedef struct packed {
    logic [7:0]           char_val;
    logic                 last;
    logic                 typed;
    uft_pkg::uft_result_t want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  url_field_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  stim_row_t            url_bytes [$];     // every request, directed rows first
  uft_pkg::uft_result_t tagged_q [$];      // tagged bytes still to come out
  logic [7:0]           url_buf [$];       // URL under construction
  int unsigned directed_len;
  int unsigned url_count;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned accept_ptr;

  // Tokenizer state as seen by the predictor.
  uft_pkg::uft_phase_t tok_phase;
  logic [15:0]         tok_port;
  logic                tok_digits_open;
  logic [2:0]          tok_scheme_len;
  logic [3:0]          tok_scheme_match;
  logic                tok_error;

  function automatic string scheme_text(input int k);
    case (k)
      0:       return "http";
      1:       return "https";
      2:       return "rtsp";
      default: return "ldap";
    endcase
  endfunction

  function automatic logic [9:0] scheme_dflt(input int k);
    case (k)
      0:       return uft_pkg::PORT_HTTP;
      1:       return uft_pkg::PORT_HTTPS;
      2:       return uft_pkg::PORT_RTSP;
      default: return uft_pkg::PORT_LDAP;
    endcase
  endfunction

  function automatic void clear_tokenizer();
    tok_phase        = uft_pkg::PH_SCHEME;
    tok_port         = uft_pkg::PORT_RESET;
    tok_digits_open  = 1'b0;
    tok_scheme_len   = 3'd0;
    tok_scheme_match = 4'hF;
    tok_error        = 1'b0;
  endfunction

  // Tags one byte, advances the tokenizer state and builds the end-of-URL report.
  function automatic uft_pkg::uft_result_t tokenize_byte(input logic [7:0] c,
                                                         input logic last);
    uft_pkg::uft_result_t r;
    string                nm;
    logic                 found;
    int                   k;
    r = '0;
    case (tok_phase)
      uft_pkg::PH_SCHEME: begin
        if (c == uft_pkg::CH_COLON) begin
          r.tag     = uft_pkg::TAG_DELIM;
          tok_phase = uft_pkg::PH_SLASH1;
        end else begin
          r.tag = uft_pkg::TAG_SCHEME;
          for (k = 0; k < 4; k++) begin
            nm = scheme_text(k);
            if (tok_scheme_match[k] &&
                (tok_scheme_len >= nm.len() || nm[tok_scheme_len] != c))
              tok_scheme_match[k] = 1'b0;
          end
          if (tok_scheme_len != 3'd7) tok_scheme_len = tok_scheme_len + 3'd1;
        end
      end
      uft_pkg::PH_SLASH1, uft_pkg::PH_SLASH2: begin
        if (c == uft_pkg::CH_SLASH) begin
          r.tag     = uft_pkg::TAG_DELIM;
          tok_phase = (tok_phase == uft_pkg::PH_SLASH1) ? uft_pkg::PH_SLASH2
                                                        : uft_pkg::PH_HOST;
        end else begin
          r.tag     = uft_pkg::TAG_AFTER_ERR;
          tok_phase = uft_pkg::PH_ERROR;
          tok_error = 1'b1;
        end
      end
      uft_pkg::PH_HOST, uft_pkg::PH_PORT: begin
        if (c == uft_pkg::CH_COLON) begin
          r.tag           = uft_pkg::TAG_DELIM;
          tok_port        = 16'd0;
          tok_digits_open = 1'b1;
          tok_phase       = uft_pkg::PH_PORT;
        end else if (c == uft_pkg::CH_SLASH) begin
          r.tag     = uft_pkg::TAG_DELIM;
          tok_phase = uft_pkg::PH_PATH;
        end else if (tok_phase == uft_pkg::PH_HOST) begin
          r.tag = uft_pkg::TAG_HOST;
        end else begin
          r.tag = uft_pkg::TAG_PORT;
          if (c >= uft_pkg::CH_DIGIT_LO && c <= uft_pkg::CH_DIGIT_HI && tok_digits_open)
            tok_port = tok_port * 16'd10 + {8'd0, c - uft_pkg::CH_DIGIT_LO};
          else
            tok_digits_open = 1'b0;
        end
      end
      uft_pkg::PH_PATH: begin
        if (c == uft_pkg::CH_QUESTION) begin
          r.tag     = uft_pkg::TAG_DELIM;
          tok_phase = uft_pkg::PH_QUERY;
        end else begin
          r.tag = uft_pkg::TAG_PATH;
        end
      end
      uft_pkg::PH_QUERY: r.tag = uft_pkg::TAG_QUERY;
      default:           r.tag = uft_pkg::TAG_AFTER_ERR;
    endcase
    r.byte_val = c;
    r.done     = last;
    if (last) begin
      // The first matching scheme gives the default port; any match may flag it.
      found         = 1'b0;
      r.scheme_port = uft_pkg::PORT_HTTP;
      for (k = 0; k < 4; k++) begin
        if (tok_scheme_match[k]) begin
          if (!found) r.scheme_port = scheme_dflt(k);
          found = 1'b1;
          if (tok_port == {6'd0, scheme_dflt(k)}) r.is_default = 1'b1;
        end
      end
      r.port_value   = tok_port;
      r.format_error = tok_error || tok_phase == uft_pkg::PH_SCHEME ||
                       tok_phase == uft_pkg::PH_SLASH1 || tok_phase == uft_pkg::PH_SLASH2;
      clear_tokenizer();
    end
    return r;
  endfunction

  function automatic uft_pkg::uft_result_t make_result(input logic [2:0] tag,
                                                       input logic [7:0] b,
                                                       input logic [15:0] port,
                                                       input logic [9:0] sport,
                                                       input logic dflt, input logic ferr);
    uft_pkg::uft_result_t r;
    r = '{tag: tag, byte_val: b, done: 1'b1, port_value: port, scheme_port: sport,
          is_default: dflt, format_error: ferr};
    return r;
  endfunction

  // Stimulus building.
  function automatic void put(input logic [7:0] c);
    url_buf.push_back(c);
  endfunction

  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_from(input string cs, input int n);
    int i;
    for (i = 0; i < n; i++) put(cs[$urandom_range(0, cs.len() - 1)]);
  endfunction

  function automatic void put_digits(input int n);
    put_from("0123456789", n);
  endfunction

  // Moves the URL under construction into the stimulus, marking its final byte.
  function automatic void flush_url();
    stim_row_t row;
    int        i;
    for (i = 0; i < url_buf.size(); i++) begin
      row          = '0;
      row.char_val = url_buf[i];
      row.last     = (i == url_buf.size() - 1);
      url_bytes.push_back(row);
    end
    url_buf.delete();
    url_count++;
  endfunction

  function automatic void add_text_url(input string s);
    put_text(s);
    flush_url();
  endfunction

  function automatic void add_typed(input logic [7:0] c, input uft_pkg::uft_result_t want);
    stim_row_t row;
    row          = '{char_val: c, last: 1'b1, typed: 1'b1, want: want};
    url_bytes.push_back(row);
    url_count++;
  endfunction

  // Mostly well-formed URLs with random content, some broken ones and some noise.
  function automatic void add_random_url();
    int    pick;
    int    k;
    bit    stop;
    string nm;
    stop = 1'b0;
    k    = $urandom_range(0, 3);
    nm   = scheme_text(k);
    if ($urandom_range(0, 9) == 0) begin
      put_from("ab:/?09", $urandom_range(0, 3));
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 9);
      case (pick)
        4: put_text(nm.substr(0, $urandom_range(0, 2)));
        5: ;
        6: begin
          put_text(nm);
          put_from("sxyz", $urandom_range(1, 4));
        end
        7: repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
        default: put_text(nm);
      endcase
      // Separator, sometimes broken or cut short.
      pick = $urandom_range(0, 19);
      case (pick)
        0: ;
        1: begin put(uft_pkg::CH_COLON); stop = 1'b1; end
        2: begin put_text(":/"); stop = 1'b1; end
        3: begin put(uft_pkg::CH_COLON); put_from("ax:?\000", 1); end
        4: begin put_text(":/"); put_from("ax:?", 1); end
        default: put_text("://");
      endcase
      if (!stop) begin
        put_from("abcxyz0189.-", $urandom_range(0, 6));
        if ($urandom_range(0, 19) == 0) put(8'($urandom_range(0, 255)));
        // Port: default values, wrapping digit runs, empty ports and repeated colons.
        pick = $urandom_range(0, 9);
        case (pick)
          4: begin put(uft_pkg::CH_COLON); put_text($sformatf("%0d", scheme_dflt(k))); end
          5: begin put(uft_pkg::CH_COLON); put_digits($urandom_range(1, 7)); end
          6: put(uft_pkg::CH_COLON);
          7: begin put(uft_pkg::CH_COLON); put_digits($urandom_range(0, 3));
                   put_from("x.", 1); put_digits($urandom_range(1, 3)); end
          8: begin put(uft_pkg::CH_COLON); put_digits($urandom_range(0, 3));
                   put(uft_pkg::CH_COLON); put_digits($urandom_range(0, 4)); end
          9: begin put(uft_pkg::CH_COLON);
                   put_text($sformatf("%0d", $urandom_range(0, 65535))); end
          default: ;
        endcase
        if ($urandom_range(0, 9) < 7) begin
          put(uft_pkg::CH_SLASH);
          put_from("ab/:.", $urandom_range(0, 6));
          if ($urandom_range(0, 1) == 1) begin
            put(uft_pkg::CH_QUESTION);
            put_from("k=v&?/:", $urandom_range(0, 5));
          end
        end
      end
    end
    if (url_buf.size() == 0) put(8'($urandom_range(0, 255)));
    flush_url();
  endfunction

  initial begin
    clear_tokenizer();
    mismatches      = 0;
    results_checked = 0;
    accept_ptr      = 0;
    url_count       = 0;
    // Directed part: empty scheme cut short, extreme bytes, a missing double slash,
    // a URL through host, port, path and query, and a long scheme that ends early.
    add_typed(uft_pkg::CH_COLON,
              make_result(uft_pkg::TAG_DELIM, uft_pkg::CH_COLON, uft_pkg::PORT_RESET,
                          uft_pkg::PORT_HTTP, 1'b1, 1'b1));
    add_typed(8'h00,
              make_result(uft_pkg::TAG_SCHEME, 8'h00, uft_pkg::PORT_RESET,
                          uft_pkg::PORT_HTTP, 1'b0, 1'b1));
    add_typed(8'hFF,
              make_result(uft_pkg::TAG_SCHEME, 8'hFF, uft_pkg::PORT_RESET,
                          uft_pkg::PORT_HTTP, 1'b0, 1'b1));
    add_text_url("rt:/x");
    add_text_url("://a:7/?z");
    add_text_url("httpsx:/");
    directed_len = url_bytes.size();
    while (url_bytes.size() < directed_len + RANDOM_BYTES) add_random_url();
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: random gaps between requests, one full drain part way through.
  int unsigned drive_ptr = 0;
  int unsigned sender_seen = 0;
  int unsigned send_gap = 0;
  bit          drained = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) drive_ptr = drive_ptr + 1;
      if (out_tvalid && out_tready) sender_seen = sender_seen + 1;
      // A request on offer stays put until it is taken.
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (drive_ptr == DRAIN_AT && !drained && sender_seen != drive_ptr) begin
          in_tvalid <= 1'b0;
        end else if (drive_ptr < url_bytes.size()) begin
          if (drive_ptr == DRAIN_AT) drained = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= url_bytes[drive_ptr].char_val;
          in_tlast  <= url_bytes[drive_ptr].last;
          if (drive_ptr + QUIET_TAIL < url_bytes.size() && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off that backs up the input.
  int unsigned sink_count = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sink_count = sink_count + 1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && sink_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if (sink_count + QUIET_TAIL < url_bytes.size() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Compares the result taken at this edge with the oldest tagged byte waiting.
  task automatic check_result();
    uft_pkg::uft_result_t want;
    int unsigned          n;
    n = results_checked;
    results_checked++;
    if (tagged_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", n));
    end else begin
      want = tagged_q.pop_front();
      if (out_tuser !== want.tag)
        report_mismatch($sformatf("result %0d field_tag %0d, expected %0d",
                                  n, out_tuser, want.tag));
      if (out_tdata[7:0] !== want.byte_val)
        report_mismatch($sformatf("result %0d byte_out %02h, expected %02h",
                                  n, out_tdata[7:0], want.byte_val));
      if (out_tlast !== want.done)
        report_mismatch($sformatf("result %0d url_done %0b, expected %0b",
                                  n, out_tlast, want.done));
      if (out_tdata[23:8] !== want.port_value)
        report_mismatch($sformatf("result %0d port_value %0d, expected %0d",
                                  n, out_tdata[23:8], want.port_value));
      if (out_tdata[33:24] !== want.scheme_port)
        report_mismatch($sformatf("result %0d scheme_port %0d, expected %0d",
                                  n, out_tdata[33:24], want.scheme_port));
      if (out_tdata[34] !== want.is_default)
        report_mismatch($sformatf("result %0d port_is_default %0b, expected %0b",
                                  n, out_tdata[34], want.is_default));
      if (out_tdata[35] !== want.format_error)
        report_mismatch($sformatf("result %0d format_error %0b, expected %0b",
                                  n, out_tdata[35], want.format_error));
      if (out_tdata[39:36] !== 4'd0)
        report_mismatch($sformatf("result %0d padding bits %0h not zero",
                                  n, out_tdata[39:36]));
    end
  endtask

  // Checker: predicts each taken request and checks each taken result.
  stim_row_t            taken_row;
  uft_pkg::uft_result_t predicted;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        if (accept_ptr >= url_bytes.size()) begin
          report_mismatch("request taken beyond the end of the stimulus");
        end else begin
          taken_row  = url_bytes[accept_ptr];
          accept_ptr = accept_ptr + 1;
          predicted  = tokenize_byte(taken_row.char_val, taken_row.last);
          tagged_q.push_back(taken_row.typed ? taken_row.want : predicted);
        end
      end
    end
  end

  // End of run: all requests taken, all results in, then a quiet wait before the summary.
  int unsigned settle;

  initial begin
    @(posedge rst_n);
    wait (accept_ptr == url_bytes.size());
    settle = 0;
    while (tagged_q.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (tagged_q.size() != 0)
      report_mismatch($sformatf("%0d tagged bytes never came out", tagged_q.size()));
    $display("Sent %0d URL bytes in %0d URLs (%0d directed), checked %0d results.",
             url_bytes.size(), url_count, directed_len, results_checked);
    $display("Run included a %0d-cycle receiver hold-off and one full drain of the block.",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d results still pending.", tagged_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
